[sv/order_book_price_levels_defines.svh]
// Assertion macros for the price level table checker.
// Depends on nothing; taken in by the checker file.
`ifndef ORDER_BOOK_PRICE_LEVELS_DEFINES_SVH
`define ORDER_BOOK_PRICE_LEVELS_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define OBPL_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("order book check failed");

// Next-cycle implication, disabled during reset
`define OBPL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("order book check failed");

`endif

[sv/obpl_pkg.sv]
// Types, widths and helpers shared by the price level table.
// Depends on nothing.
package obpl_pkg;

   localparam int LEVELS_DEF = 16;
   localparam int PRICE_W    = 32;
   localparam int QTY_W      = 31;

   typedef struct packed {
      logic               side;
      logic [PRICE_W-1:0] price;
      logic [QTY_W-1:0]   quantity;
   } req_type;

   typedef struct packed {
      logic [PRICE_W-1:0] best_bid_price;
      logic [QTY_W-1:0]   best_bid_qty;
      logic               bid_present;
      logic [PRICE_W-1:0] best_ask_price;
      logic [QTY_W-1:0]   best_ask_qty;
      logic               ask_present;
      logic               side_full;
   } rsp_type;

   typedef struct packed {
      logic               valid;
      logic [PRICE_W-1:0] price;
      logic [QTY_W-1:0]   qty;
   } level_type;

   typedef struct packed {
      logic               act;
      logic               remove;
      logic               found;
      logic               full;
      logic [PRICE_W-1:0] price;
      logic [QTY_W-1:0]   qty;
   } cell_cmd_type;

   function automatic logic goes_before(input logic descending,
                                        input logic [PRICE_W-1:0] p,
                                        input logic [PRICE_W-1:0] q);
      goes_before = descending ? (p > q) : (p < q);
   endfunction

endpackage

[sv/obpl_chan_if.sv]
// Valid/ready channel carrying one request or result payload.
// Depends on obpl_pkg for payload types at the point of use.
interface obpl_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[sv/obpl_cell.sv]
// One price level cell: holds a level, shifts with its neighbours on insert/remove.
// Depends on obpl_pkg.
module obpl_cell #(
   parameter bit DESCENDING = 1'b1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  obpl_pkg::cell_cmd_type cmd,
   input  obpl_pkg::level_type    left_level,
   input  logic                  left_before,
   input  obpl_pkg::level_type    right_level,
   output obpl_pkg::level_type    level,
   output obpl_pkg::level_type    level_next,
   output logic                  ahead,
   output logic                  match
);

   obpl_pkg::level_type level_ff;
   obpl_pkg::level_type level_in;

   assign ahead = !level_ff.valid
                  || obpl_pkg::goes_before(DESCENDING, cmd.price, level_ff.price);
   assign match = level_ff.valid && (level_ff.price == cmd.price);

   always_comb begin
      level_in = level_ff;
      if (cmd.act) begin
         if (cmd.remove) begin
            if (cmd.found && (ahead || match)) begin
               level_in = right_level;
            end
         end else if (cmd.found) begin
            if (match) begin
               level_in.qty = cmd.qty;
            end
         end else if (!cmd.full) begin
            if (left_before) begin
               level_in = left_level;
            end else if (ahead) begin
               level_in.valid = 1'b1;
               level_in.price = cmd.price;
               level_in.qty   = cmd.qty;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff.valid <= 1'b0;
      end else begin
         level_ff <= level_in;
      end
   end

   assign level      = level_ff;
   assign level_next = level_in;

endmodule

[sv/obpl_row.sv]
// One side of the book: a sorted chain of level cells, best level in cell 0.
// Depends on obpl_pkg and obpl_cell.
module obpl_row #(
   parameter int LEVELS     = obpl_pkg::LEVELS_DEF,
   parameter bit DESCENDING = 1'b1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   act,
   input  logic [obpl_pkg::PRICE_W-1:0] price,
   input  logic [obpl_pkg::QTY_W-1:0]   qty,
   output obpl_pkg::level_type     best_next,
   output logic                   dropped
);

   obpl_pkg::level_type    levels [LEVELS];
   obpl_pkg::level_type    nexts  [LEVELS];
   logic [LEVELS-1:0]      ahead_vec;
   logic [LEVELS-1:0]      match_vec;
   obpl_pkg::cell_cmd_type cmd;

   always_comb begin
      cmd.act    = act;
      cmd.remove = (qty == '0);
      cmd.found  = |match_vec;
      cmd.full   = levels[LEVELS-1].valid;
      cmd.price  = price;
      cmd.qty    = qty;
   end

   for (genvar i = 0; i < LEVELS; i++) begin : g_cell
      obpl_pkg::level_type left_l;
      obpl_pkg::level_type right_l;
      logic               left_b;

      if (i == 0) begin : g_head
         assign left_l = '0;
         assign left_b = 1'b0;
      end else begin : g_body
         assign left_l = levels[i-1];
         assign left_b = ahead_vec[i-1];
      end

      if (i == LEVELS - 1) begin : g_tail
         assign right_l = '0;
      end else begin : g_mid
         assign right_l = levels[i+1];
      end

      obpl_cell #(.DESCENDING(DESCENDING)) u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .left_level  (left_l),
         .left_before (left_b),
         .right_level (right_l),
         .level       (levels[i]),
         .level_next  (nexts[i]),
         .ahead       (ahead_vec[i]),
         .match       (match_vec[i])
      );
   end

   assign best_next = nexts[0];
   assign dropped   = act && !cmd.remove && !cmd.found && cmd.full;

endmodule

[sv/order_book_price_levels.sv]
// Top level of the two-sided price level table: request register, bid and ask rows, result register.
// Depends on obpl_pkg, obpl_chan_if and obpl_row.
//
//   Channel   Dir   Payload   Handshake
//   req_chan  in    req_type  valid/ready
//   rsp_chan  out   rsp_type  valid/ready
//
// One request per cycle sustained while results are accepted; a taken request is registered in
// the request register and its result in the result register. Each row of cells applies insert,
// overwrite or remove as a registered update; the request and result registers sit either side of it.
// Synchronous reset empties both sides and drops any request in flight.
// A stalled result holds the held request; the input stalls only while both are occupied.
module order_book_price_levels #(
   parameter int LEVELS = obpl_pkg::LEVELS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   obpl_chan_if.sink   req_chan,
   obpl_chan_if.source rsp_chan
);

   logic                pend_ff;
   obpl_pkg::req_type    req_ff;
   logic                rsp_valid_ff;
   obpl_pkg::rsp_type    rsp_ff;
   obpl_pkg::rsp_type    rsp_in;
   logic                advance;
   obpl_pkg::level_type  bid_best;
   obpl_pkg::level_type  ask_best;
   logic                bid_drop;
   logic                ask_drop;

   assign advance        = pend_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !pend_ff || advance;

   obpl_row #(.LEVELS(LEVELS), .DESCENDING(1'b1)) u_bid (
      .clock     (clock),
      .reset     (reset),
      .act       (advance && !req_ff.side),
      .price     (req_ff.price),
      .qty       (req_ff.quantity),
      .best_next (bid_best),
      .dropped   (bid_drop)
   );

   obpl_row #(.LEVELS(LEVELS), .DESCENDING(1'b0)) u_ask (
      .clock     (clock),
      .reset     (reset),
      .act       (advance && req_ff.side),
      .price     (req_ff.price),
      .qty       (req_ff.quantity),
      .best_next (ask_best),
      .dropped   (ask_drop)
   );

   always_comb begin
      rsp_in.best_bid_price = bid_best.valid ? bid_best.price : '0;
      rsp_in.best_bid_qty   = bid_best.valid ? bid_best.qty : '0;
      rsp_in.bid_present    = bid_best.valid;
      rsp_in.best_ask_price = ask_best.valid ? ask_best.price : '0;
      rsp_in.best_ask_qty   = ask_best.valid ? ask_best.qty : '0;
      rsp_in.ask_present    = ask_best.valid;
      rsp_in.side_full      = bid_drop || ask_drop;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            pend_ff <= 1'b1;
            req_ff  <= req_chan.payload;
         end else if (advance) begin
            pend_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            rsp_ff       <= rsp_in;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

endmodule

[sv/obpl_checker.sv]
// Port-level checks on the price level table, bound to the top level.
// Depends on obpl_pkg and order_book_price_levels_defines.svh.
`include "order_book_price_levels_defines.svh"

module obpl_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input obpl_pkg::rsp_type rsp_payload
);

   `OBPL_ASSERT_IMPLY(a_no_bid_zero, clock, reset, rsp_valid && !rsp_payload.bid_present, rsp_payload.best_bid_price == '0 && rsp_payload.best_bid_qty == '0)
   `OBPL_ASSERT_IMPLY(a_no_ask_zero, clock, reset, rsp_valid && !rsp_payload.ask_present, rsp_payload.best_ask_price == '0 && rsp_payload.best_ask_qty == '0)
   `OBPL_ASSERT_IMPLY(a_rsp_from_req, clock, reset, $rose(rsp_valid), $past(req_valid && req_ready, 2))
   `OBPL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))

endmodule

bind order_book_price_levels obpl_checker u_obpl_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload)
);

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// Self-checking bench for the two-sided price level table: predicts best bid and ask per request.
// Depends on obpl_pkg, obpl_chan_if and order_book_price_levels.
module testbench;

   localparam int LEVELS      = 16;
   localparam int STALL_LIMIT = 2000;
   localparam bit SIDE_BID    = 1'b0;
   localparam bit SIDE_ASK    = 1'b1;

   logic clock;
   logic reset;

   obpl_chan_if #(.payload_type(obpl_pkg::req_type)) req_chan ();
   obpl_chan_if #(.payload_type(obpl_pkg::rsp_type)) rsp_chan ();

   order_book_price_levels #(.LEVELS(LEVELS)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   obpl_pkg::rsp_type expected_books[$];
   obpl_pkg::rsp_type want;
   logic [31:0]       book_px[2][LEVELS];
   logic [30:0]       book_qt[2][LEVELS];
   int                book_n[2];
   int                errors;
   int                idle_cycles;
   int                hold_count;
   int                long_stall_request;
   bit                source_idling;
   bit                sink_idling;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int gap_length();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic obpl_pkg::rsp_type book_after_update(input obpl_pkg::req_type r);
      obpl_pkg::rsp_type book;
      int                s;
      int                at;
      int                i;
      bit                found;
      s     = int'(r.side);
      at    = book_n[s];
      found = 1'b0;
      book  = '0;
      for (i = 0; i < book_n[s]; i++) begin
         if (!found && book_px[s][i] == r.price) begin
            at    = i;
            found = 1'b1;
         end
      end
      if (r.quantity == '0) begin
         if (found) begin
            for (i = at; i + 1 < book_n[s]; i++) begin
               book_px[s][i] = book_px[s][i + 1];
               book_qt[s][i] = book_qt[s][i + 1];
            end
            book_n[s]--;
         end
      end else if (found) begin
         book_qt[s][at] = r.quantity;
      end else if (book_n[s] >= LEVELS) begin
         book.side_full = 1'b1;
      end else begin
         at = 0;
         while (at < book_n[s] && !((s == SIDE_BID) ? (r.price > book_px[s][at])
                                                     : (r.price < book_px[s][at])))
            at++;
         for (i = book_n[s]; i > at; i--) begin
            book_px[s][i] = book_px[s][i - 1];
            book_qt[s][i] = book_qt[s][i - 1];
         end
         book_px[s][at] = r.price;
         book_qt[s][at] = r.quantity;
         book_n[s]++;
      end
      if (book_n[SIDE_BID] > 0) begin
         book.best_bid_price = book_px[SIDE_BID][0];
         book.best_bid_qty   = book_qt[SIDE_BID][0];
         book.bid_present    = 1'b1;
      end
      if (book_n[SIDE_ASK] > 0) begin
         book.best_ask_price = book_px[SIDE_ASK][0];
         book.best_ask_qty   = book_qt[SIDE_ASK][0];
         book.ask_present    = 1'b1;
      end
      return book;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] exp_val,
                                       input logic [31:0] act_val);
      if (exp_val !== act_val) begin
         $error("%s: expected %0h, actual %0h", name, exp_val, act_val);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_books.size() == 0) begin
               $error("result with no request outstanding");
               errors++;
            end else begin
               want = expected_books.pop_front();
               check_field("best_bid_price", want.best_bid_price,
                           rsp_chan.payload.best_bid_price);
               check_field("best_bid_qty", 32'(want.best_bid_qty),
                           32'(rsp_chan.payload.best_bid_qty));
               check_field("bid_present", 32'(want.bid_present),
                           32'(rsp_chan.payload.bid_present));
               check_field("best_ask_price", want.best_ask_price,
                           rsp_chan.payload.best_ask_price);
               check_field("best_ask_qty", 32'(want.best_ask_qty),
                           32'(rsp_chan.payload.best_ask_qty));
               check_field("ask_present", 32'(want.ask_present),
                           32'(rsp_chan.payload.ask_present));
               check_field("side_full", 32'(want.side_full),
                           32'(rsp_chan.payload.side_full));
            end
         end
         if (req_chan.valid && req_chan.ready)
            expected_books.push_back(book_after_update(req_chan.payload));
      end
   end

   initial begin
      rsp_chan.ready = 1'b0;
      hold_count     = 0;
      forever begin
         @(negedge clock);
         if (hold_count == 0) begin
            if (long_stall_request > 0) begin
               hold_count         = long_stall_request;
               long_stall_request = 0;
            end else if (sink_idling && $urandom_range(0, 99) < 20) begin
               hold_count = gap_length();
            end
         end
         if (hold_count > 0) begin
            rsp_chan.ready <= 1'b0;
            hold_count--;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   initial begin
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("FAIL order_book_price_levels");
      $finish;
   end

   task automatic send_update(input logic side, input logic [31:0] price,
                              input logic [30:0] qty);
      if (source_idling && $urandom_range(0, 99) < 25) begin
         req_chan.valid <= 1'b0;
         repeat (gap_length()) @(negedge clock);
      end
      req_chan.valid            <= 1'b1;
      req_chan.payload.side     <= side;
      req_chan.payload.price    <= price;
      req_chan.payload.quantity <= qty;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   function automatic logic [31:0] pick_price(input int s, input int existing_pct);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (book_n[s] > 0 && roll < existing_pct)
         return book_px[s][$urandom_range(0, book_n[s] - 1)];
      roll = $urandom_range(0, 99);
      if (roll < 50) return 32'd1000 + $urandom_range(0, 40);
      if (roll < 65) return $urandom_range(0, 15);
      if (roll < 80) return 32'hFFFF_FFFF - $urandom_range(0, 15);
      return $urandom;
   endfunction

   function automatic logic [30:0] pick_qty(input int remove_pct);
      logic [30:0] qty;
      int unsigned roll;
      if ($urandom_range(0, 99) < remove_pct) return '0;
      roll = $urandom_range(0, 9);
      if (roll == 0) return {31{1'b1}};
      if (roll < 5) return 31'($urandom_range(1, 500));
      qty = 31'($urandom);
      if (qty == '0) qty = 31'd1;
      return qty;
   endfunction

   task automatic send_random(input logic side, input int remove_pct);
      logic [30:0] qty;
      qty = pick_qty(remove_pct);
      send_update(side, pick_price(int'(side), (qty == '0) ? 80 : 35), qty);
   endtask

   task automatic test_extreme_prices();
      send_update(SIDE_BID, 32'h0000_0000, 31'd0);
      send_update(SIDE_BID, 32'hFFFF_FFFF, {31{1'b1}});
      send_update(SIDE_ASK, 32'h0000_0000, 31'd1);
      send_update(SIDE_ASK, 32'hFFFF_FFFF, {31{1'b1}});
      send_update(SIDE_BID, 32'h0000_0000, 31'd1);
      send_update(SIDE_ASK, 32'h0000_0000, 31'd0);
      send_update(SIDE_BID, 32'hFFFF_FFFF, 31'd0);
      send_update(SIDE_ASK, 32'hFFFF_FFFF, 31'd0);
      send_update(SIDE_ASK, 32'h1234_5678, 31'd0);
   endtask

   task automatic test_fill_and_overflow();
      int k;
      for (k = 1; k < LEVELS; k++)
         send_update(SIDE_BID, 32'd1000 + ((k * 7) % LEVELS) * 10, 31'(100 + k));
      send_update(SIDE_BID, 32'd2000, 31'd9);
      send_update(SIDE_BID, 32'h0000_0000, {31{1'b1}});
      send_update(SIDE_BID, 32'd3, 31'd0);
   endtask

   task automatic test_back_to_back();
      int k;
      source_idling = 1'b0;
      sink_idling   = 1'b0;
      for (k = 0; k < 150; k++)
         send_random(1'($urandom_range(0, 1)), (k < 75) ? 20 : 50);
      source_idling = 1'b1;
      sink_idling   = 1'b1;
   endtask

   task automatic test_result_backpressure();
      int k;
      long_stall_request = 160;
      for (k = 0; k < 40; k++)
         send_random(1'($urandom_range(0, 1)), 25);
   endtask

   task automatic test_full_ask_side();
      int k;
      while (book_n[SIDE_ASK] < LEVELS)
         send_update(SIDE_ASK, $urandom_range(0, 255), pick_qty(0));
      for (k = 0; k < 60; k++)
         send_update(SIDE_ASK,
                     (k % 2) ? $urandom_range(0, 255) : pick_price(int'(SIDE_ASK), 50),
                     pick_qty(10));
   endtask

   task automatic test_random_churn();
      int k;
      for (k = 0; k < 1050; k++)
         send_random(1'($urandom_range(0, 1)), ((k / 100) % 2) ? 55 : 12);
   endtask

   initial begin
      reset                    = 1'b1;
      req_chan.valid           = 1'b0;
      req_chan.payload         = '0;
      errors                   = 0;
      book_n[SIDE_BID]         = 0;
      book_n[SIDE_ASK]         = 0;
      long_stall_request       = 0;
      source_idling            = 1'b1;
      sink_idling              = 1'b1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_extreme_prices();
      test_fill_and_overflow();
      test_back_to_back();
      test_result_backpressure();
      test_full_ask_side();
      test_random_churn();

      req_chan.valid <= 1'b0;
      while (expected_books.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (errors == 0)
         $display("PASS order_book_price_levels");
      else
         $display("FAIL order_book_price_levels");
      $finish;
   end

endmodule

[filelist.f]
+incdir+sv
sv/obpl_pkg.sv
sv/obpl_chan_if.sv
sv/obpl_cell.sv
sv/obpl_row.sv
sv/order_book_price_levels.sv
sv/obpl_checker.sv
tb/sv/testbench.sv
